// ===== hdl/b64d_pkg.sv =====
// Package with the shared types, constants and functions of the base64 decoder.
`default_nettype none

package b64d_pkg;

	localparam int COUNT_BITS = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int TOTAL_BITS = 16;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [5:0] sextet_t;

	typedef enum logic [1:0] {
		KIND_SEXTET,
		KIND_PAD,
		KIND_SKIP,
		KIND_BAD
	} char_kind_t;

	typedef struct packed {
		char_kind_t kind;
		sextet_t    value;
	} char_class_t;

	// Everything one accepted character leaves for the output side.
	typedef struct packed {
		logic [1:0]            n_data;
		logic [7:0]            byte0;
		logic [7:0]            byte1;
		logic [7:0]            byte2;
		logic                  report;
		logic [TOTAL_BITS-1:0] total;
		logic                  stopped;
	} bundle_t;

	function automatic char_class_t classify(logic [7:0] c);
		char_class_t r;
		r.kind  = KIND_BAD;
		r.value = '0;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r.kind  = KIND_SEXTET;
			r.value = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			r.kind  = KIND_SEXTET;
			r.value = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.kind  = KIND_SEXTET;
			r.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2b) begin
			r.kind  = KIND_SEXTET;
			r.value = 6'd62;
		end else if (c == 8'h2f) begin
			r.kind  = KIND_SEXTET;
			r.value = 6'd63;
		end else if (c == 8'h3d) begin
			r.kind = KIND_PAD;
		end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) begin
			r.kind = KIND_SKIP;
		end
		return r;
	endfunction

	function automatic logic [TOTAL_BITS-1:0] to_total(count_t c);
		logic [31:0] w;
		w = 32'(c);
		return w[TOTAL_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/b64d_text_if.sv =====
// Channel interface that carries base64 characters into the decoder.
`default_nettype none

interface b64d_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== hdl/b64d_result_if.sv =====
// Channel interface that carries decoded bytes and end of text reports.
`default_nettype none

interface b64d_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        is_report;
	logic [15:0] byte_total;
	logic        stopped_early;
	logic        last;

	modport source (
		output valid, output data_byte, output is_report, output byte_total,
		output stopped_early, output last, input ready
	);
	modport sink (
		input valid, input data_byte, input is_report, input byte_total,
		input stopped_early, input last, output ready
	);
endinterface

`default_nettype wire

// ===== hdl/b64d_decode.sv =====
// Character classification, group state and byte assembly of the base64 decoder.
`default_nettype none

module b64d_decode (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      char_code,
	input  wire logic            end_of_text,
	output b64d_pkg::bundle_t    bundle,
	output logic                 has_result
);
	import b64d_pkg::*;

	logic [1:0]        gp_q, gp_n;
	logic [2:0][5:0]   store_q, store_n;
	logic [1:0]        bpg_q, bpg_n;
	logic              halt_q, halt_n;
	count_t            cnt_q, cnt_n;
	char_class_t       cls;
	logic              complete;
	sextet_t           fourth;
	logic [COUNT_BITS:0] sum;

	always_comb begin
		cls      = classify(char_code);
		gp_n     = gp_q;
		store_n  = store_q;
		bpg_n    = bpg_q;
		halt_n   = halt_q;
		cnt_n    = cnt_q;
		complete = 1'b0;
		fourth   = cls.value;
		sum      = '0;
		bundle   = '0;

		if (!halt_q) begin
			case (cls.kind)
				KIND_BAD: begin
					halt_n = 1'b1;
				end
				KIND_PAD: begin
					if (gp_q == 2'd0) begin
						halt_n = 1'b1;
					end else begin
						bpg_n    = (gp_q == 2'd3) ? 2'd2 : 2'd1;
						fourth   = 6'h3f;
						complete = 1'b1;
					end
				end
				KIND_SEXTET: begin
					case (gp_q)
						2'd0: begin
							store_n[0] = cls.value;
						end
						2'd1: begin
							store_n[1] = cls.value;
						end
						2'd2: begin
							store_n[2] = cls.value;
						end
						default: begin
							complete = 1'b1;
						end
					endcase
					if (gp_q != 2'd3) begin
						gp_n = gp_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end

		bundle.byte0 = {store_q[0], store_q[1][5:4]};
		bundle.byte1 = {store_q[1][3:0], store_q[2][5:2]};
		bundle.byte2 = {store_q[2][1:0], fourth};

		if (complete) begin
			bundle.n_data = bpg_n;
			gp_n          = 2'd0;
			sum           = {1'b0, cnt_q} + (COUNT_BITS + 1)'(bpg_n);
			cnt_n         = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
		end

		bundle.report  = end_of_text;
		bundle.total   = to_total(cnt_n);
		bundle.stopped = halt_n;
		has_result     = complete || end_of_text;

		if (end_of_text) begin
			gp_n   = 2'd0;
			bpg_n  = 2'd3;
			halt_n = 1'b0;
			cnt_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q    <= 2'd0;
			store_q <= '0;
			bpg_q   <= 2'd3;
			halt_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (accept) begin
			gp_q    <= gp_n;
			store_q <= store_n;
			bpg_q   <= bpg_n;
			halt_q  <= halt_n;
			cnt_q   <= cnt_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/b64d_fifo.sv =====
// Small queue of result bundles between the decoder and the output serializer.
`default_nettype none

module b64d_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire b64d_pkg::bundle_t wr_data,
	input  wire logic              rd_en,
	output b64d_pkg::bundle_t      rd_data,
	output logic                   full,
	output logic                   not_empty
);
	import b64d_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	bundle_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full && !rd_en))
		else $error("Bundle written into a full queue.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> not_empty)
		else $error("Bundle read from an empty queue.");

endmodule

`default_nettype wire

// ===== hdl/b64d_serial.sv =====
// Output stage: bytes and any report per bundle, one item per cycle unless stalled.
`default_nettype none

module b64d_serial (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fifo_valid,
	input  wire b64d_pkg::bundle_t fifo_data,
	output logic                   fifo_pop,
	b64d_result_if.source          result
);
	import b64d_pkg::*;

	bundle_t    cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic       is_data;
	logic       out_last;
	logic       fire;

	always_comb begin
		last_idx = cur_q.report ? cur_q.n_data : cur_q.n_data - 2'd1;
		is_data  = (idx_q < cur_q.n_data);
		out_last = (idx_q == last_idx);
		fire     = result.valid && result.ready;
		fifo_pop = fifo_valid && (!cur_valid_q || (fire && out_last));
	end

	always_comb begin
		result.valid         = cur_valid_q;
		result.last          = out_last;
		result.is_report     = !is_data;
		result.byte_total    = is_data ? '0 : cur_q.total;
		result.stopped_early = !is_data && cur_q.stopped;
		result.data_byte     = '0;
		if (is_data) begin
			case (idx_q)
				2'd0: begin
					result.data_byte = cur_q.byte0;
				end
				2'd1: begin
					result.data_byte = cur_q.byte1;
				end
				default: begin
					result.data_byte = cur_q.byte2;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			cur_q <= fifo_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (fifo_pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (fire) begin
			if (out_last) begin
				cur_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	a_report_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.is_report |-> result.last)
		else $error("Report item not marked as last.");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> idx_q <= last_idx)
		else $error("Result index ran past the end of its bundle.");

	a_bundle_continues: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !out_last |=> result.valid && (idx_q == $past(idx_q) + 2'd1))
		else $error("Bundle did not continue with its next item.");

endmodule

`default_nettype wire

// ===== hdl/base64_decoder.sv =====
// Top level of the streaming base64 decoder.
//
// The text channel takes one character per item, with end_of_text set on the
// final character of a text. The result channel gives decoded bytes one per
// item, and after the final character a report item with the byte total and
// the stop flag; last marks the final result caused by one character.
// A character is accepted in every cycle while the four-entry bundle queue
// between the decoder and the output stage has room. All work on a character
// is done in the cycle of its acceptance; its results are registered in the
// queue and then the output stage, and leave one item per cycle unless stalled.
// Four characters give at most three bytes, so a receiver that takes one item
// per cycle never slows the sender for complete groups.
// When the receiver stalls, the current result holds and the queue fills;
// ready on the text channel drops once the queue is full.
// Reset clears the group position, byte count, halt flag and sextet store,
// and sets the bytes per group to three; no item is in flight afterwards.
`default_nettype none

module base64_decoder (
	input  wire logic      clk,
	input  wire logic      arst_n,
	b64d_text_if.sink      text,
	b64d_result_if.source  result
);
	import b64d_pkg::*;

	bundle_t dec_bundle;
	bundle_t fifo_data;
	logic    has_result;
	logic    accept;
	logic    fifo_full;
	logic    fifo_valid;
	logic    fifo_pop;

	assign text.ready = !fifo_full;
	assign accept     = text.valid && text.ready;

	b64d_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.char_code   (text.char_code),
		.end_of_text (text.end_of_text),
		.bundle      (dec_bundle),
		.has_result  (has_result)
	);

	b64d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept && has_result),
		.wr_data   (dec_bundle),
		.rd_en     (fifo_pop),
		.rd_data   (fifo_data),
		.full      (fifo_full),
		.not_empty (fifo_valid)
	);

	b64d_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_valid (fifo_valid),
		.fifo_data  (fifo_data),
		.fifo_pop   (fifo_pop),
		.result     (result)
	);

endmodule

`default_nettype wire
